// File: rtl/core/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg: shared types and constants of the thermistor converter
// Widths, fixed-point constants, class codes and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none
package tbc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int VOLT_W   = 16;
  localparam int BETA_W   = 16;
  localparam int RES_W    = 24;
  localparam int DATA_W   = 24;
  localparam int INDEX_W  = 8;
  localparam int PROD_W   = VOLT_W + RES_W;   // num and den products
  localparam int EXP_W    = 6;                // msb index of a PROD_W value
  localparam int LOG_FRAC = 24;
  localparam int MANT_FRAC = 30;
  localparam int MANT_W   = MANT_FRAC + 1;
  localparam int LOG_W    = EXP_W + LOG_FRAC;
  localparam int LOG2_LAT = LOG_FRAC + 2;     // lzc, normalise, squarings
  localparam int LN_W     = LOG_W + 1;        // signed ln in Q24
  localparam int DSUM_W   = 49;
  localparam int DD_W     = DSUM_W - 1;
  localparam int NUM_W    = 55;               // 29815*B << 24
  localparam int DIV_W    = 60;
  localparam int KINT_W   = 10;
  localparam int STATUS_W = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int DEF_OUT_FRAC_BITS = 8;

  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [14:0] T0_X100     = 15'd29815;
  localparam logic [6:0]  BETA_SCALE  = 7'd100;
  localparam longint      ZERO_C_X100 = 27315;
  localparam logic [KINT_W-1:0] KELVIN_CAP = 10'd1000;

  localparam logic [INDEX_W-1:0] REG_SUPPLY  = 8'd0;
  localparam logic [INDEX_W-1:0] REG_BETA    = 8'd1;
  localparam logic [INDEX_W-1:0] REG_SERIES  = 8'd2;
  localparam logic [INDEX_W-1:0] REG_NOMINAL = 8'd3;

  localparam logic [VOLT_W-1:0] SUPPLY_RESET  = 16'd3300;
  localparam logic [BETA_W-1:0] BETA_RESET    = 16'd3950;
  localparam logic [RES_W-1:0]  SERIES_RESET  = 24'd10;
  localparam logic [RES_W-1:0]  NOMINAL_RESET = 24'd10;

  // Classification of a sample, refined in the back end.
  localparam logic [1:0] CLS_OK    = 2'd0;
  localparam logic [1:0] CLS_RANGE = 2'd1;
  localparam logic [1:0] CLS_MAX   = 2'd2;
  localparam logic [1:0] CLS_MIN   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic [1:0]        cls;
    logic [PROD_W-1:0] num;
    logic [PROD_W-1:0] den;
  } item_t;

  typedef struct packed {
    logic [VOLT_W-1:0] supply;
    logic [BETA_W-1:0] beta;
    logic [RES_W-1:0]  series;
    logic [RES_W-1:0]  nominal;
  } cfg_t;

  // Index of the most significant set bit (zero for a zero input).
  function automatic logic [EXP_W-1:0] msb_index(input logic [PROD_W-1:0] x);
    logic [EXP_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (x[i]) idx = EXP_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/thermistor_beta_to_celsius.sv
// ----------------------------------------------------------------------------
// thermistor_beta_to_celsius: NTC divider voltage to temperature
// Beta-equation converter with a classifying front end, a short queue and a
// fully pipelined arithmetic back end.
// ----------------------------------------------------------------------------
//  Channel   Signals                                     Beat when
//  ------    ------------------------------------------  --------------------
//  sample    push, full, sample_millivolts               push && !full
//  result    empty, pop, celsius_q8, status              pop && !empty
//  config    wr_en, wr_index, wr_data                    wr_en
//
// One sample beat is taken per cycle while full is low. With the result
// side draining, a beat passes 43 + OUT_FRAC_BITS registers: the front
// register, one queue slot, 26 logarithm stages, four for the log
// difference, ln scaling, denominator and division set-up, one per quotient
// bit (10 + OUT_FRAC_BITS) and the result register. The first of them is
// loaded at the edge that takes the beat. A result left waiting stalls the
// back end as a whole; the queue and the front register keep taking samples
// until they fill. Reset is synchronous, clears all control state and loads
// the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module thermistor_beta_to_celsius #(
  parameter int OUT_FRAC_BITS = tbc_pkg::DEF_OUT_FRAC_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [tbc_pkg::SAMPLE_W-1:0]  sample_millivolts,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [OUT_FRAC_BITS+9:0]    celsius_q8,
  output logic [tbc_pkg::STATUS_W-1:0]       status,
  input  wire logic                          wr_en,
  input  wire logic [tbc_pkg::INDEX_W-1:0]   wr_index,
  input  wire logic [tbc_pkg::DATA_W-1:0]    wr_data
);

  // Configuration registers. Writes to an unknown index are dropped, and
  // the data is cut to the width of the register that it lands in.
  tbc_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.supply  <= tbc_pkg::SUPPLY_RESET;
      cfg.beta    <= tbc_pkg::BETA_RESET;
      cfg.series  <= tbc_pkg::SERIES_RESET;
      cfg.nominal <= tbc_pkg::NOMINAL_RESET;
    end else if (wr_en) begin
      case (wr_index)
        tbc_pkg::REG_SUPPLY:  cfg.supply  <= wr_data[tbc_pkg::VOLT_W-1:0];
        tbc_pkg::REG_BETA:    cfg.beta    <= wr_data[tbc_pkg::BETA_W-1:0];
        tbc_pkg::REG_SERIES:  cfg.series  <= wr_data[tbc_pkg::RES_W-1:0];
        tbc_pkg::REG_NOMINAL: cfg.nominal <= wr_data[tbc_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  // The front end forms both divider products and tags each sample with
  // its class, so that the back end only ever runs one uniform pipeline.
  logic           q_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  tbc_pkg::item_t q_wdata;
  tbc_pkg::item_t q_rdata;
  logic           back_ready;

  tbc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .sample_millivolts (sample_millivolts),
    .cfg               (cfg),
    .q_push            (q_push),
    .q_item            (q_wdata),
    .q_full            (q_full)
  );

  tbc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // The back end takes a beat from the queue whenever it advances.
  assign q_pop = back_ready && !q_empty;

  tbc_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (!q_empty),
    .in_item    (q_rdata),
    .in_ready   (back_ready),
    .beta       (cfg.beta),
    .empty      (empty),
    .pop        (pop),
    .celsius_q8 (celsius_q8),
    .status     (status)
  );

endmodule
`default_nettype wire

// File: rtl/core/tbc_front.sv
// ----------------------------------------------------------------------------
// tbc_front: sample intake and classification
// Registers a sample, forms the divider products and sorts out special cases.
// ----------------------------------------------------------------------------
`default_nettype none
module tbc_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [tbc_pkg::SAMPLE_W-1:0]  sample_millivolts,
  input  wire tbc_pkg::cfg_t                 cfg,
  output logic                               q_push,
  output tbc_pkg::item_t                     q_item,
  input  wire logic                          q_full
);

  logic                         valid;
  logic                         valid_next;
  logic [tbc_pkg::SAMPLE_W-1:0] v;
  logic [tbc_pkg::VOLT_W-1:0]   diff;
  logic                         accept;

  assign full   = valid && q_full;
  assign accept = push && !full;
  assign q_push = valid && !q_full;

  always_comb begin
    valid_next = valid;
    if (accept) begin
      valid_next = 1'b1;
    end else if (q_push) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v <= sample_millivolts;
    end
  end

  always_comb begin
    diff       = cfg.supply - v;
    q_item.num = tbc_pkg::PROD_W'(diff) * tbc_pkg::PROD_W'(cfg.series);
    q_item.den = tbc_pkg::PROD_W'(v) * tbc_pkg::PROD_W'(cfg.nominal);
    // Range error wins over the zero-resistance cases.
    if (v == '0 || v >= cfg.supply) begin
      q_item.cls = tbc_pkg::CLS_RANGE;
    end else if (q_item.num == '0) begin
      q_item.cls = tbc_pkg::CLS_MAX;
    end else if (q_item.den == '0) begin
      q_item.cls = tbc_pkg::CLS_MIN;
    end else begin
      q_item.cls = tbc_pkg::CLS_OK;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tbc_queue.sv
// ----------------------------------------------------------------------------
// tbc_queue: short queue between front and back end
// A small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tbc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tbc_pkg::item_t  wdata,
  output logic                 full,
  input  wire logic            pop,
  output tbc_pkg::item_t       rdata,
  output logic                 empty
);

  localparam int PTR_W = $clog2(tbc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tbc_pkg::QUEUE_DEPTH + 1);

  tbc_pkg::item_t   mem [tbc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(tbc_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(tbc_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(tbc_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(tbc_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("front pushed into a full queue");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on a pop beat");

endmodule
`default_nettype wire

// File: rtl/core/tbc_log2.sv
// ----------------------------------------------------------------------------
// tbc_log2: pipelined base-2 logarithm
// Leading-one search, normalisation to Q30, then one squaring per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module tbc_log2 (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [tbc_pkg::PROD_W-1:0]  x,
  output logic [tbc_pkg::LOG_W-1:0]        result
);

  localparam int MW = tbc_pkg::MANT_W;
  localparam int NS = tbc_pkg::LOG_FRAC;

  logic [tbc_pkg::PROD_W-1:0]  x1;
  logic [tbc_pkg::EXP_W-1:0]   e1;
  logic [MW-1:0]               m_norm;
  logic [tbc_pkg::PROD_W+MW-1:0] shl;
  logic [MW-1:0]               m  [NS+1];
  logic [tbc_pkg::EXP_W-1:0]   ex [NS+1];
  logic [NS-1:0]               f  [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x;
      e1 <= tbc_pkg::msb_index(x);
    end
  end

  always_comb begin
    shl = (tbc_pkg::PROD_W + MW)'(x1)
          << (tbc_pkg::EXP_W'(tbc_pkg::MANT_FRAC) - e1);
    if (e1 <= tbc_pkg::EXP_W'(tbc_pkg::MANT_FRAC)) begin
      m_norm = shl[MW-1:0];
    end else begin
      m_norm = MW'(x1 >> (e1 - tbc_pkg::EXP_W'(tbc_pkg::MANT_FRAC)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0]  <= m_norm;
      ex[0] <= e1;
      f[0]  <= '0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     t;
    assign sq = (2*MW)'(m[i]) * (2*MW)'(m[i]);
    assign t  = sq[tbc_pkg::MANT_FRAC +: MW+1];
    always_ff @(posedge clk) begin
      if (en) begin
        m[i+1]  <= t[MW] ? t[MW:1] : t[MW-1:0];
        f[i+1]  <= {f[i][NS-2:0], t[MW]};
        ex[i+1] <= ex[i];
      end
    end
  end

  assign result = {ex[NS], f[NS]};

endmodule
`default_nettype wire

// File: rtl/core/tbc_back.sv
// ----------------------------------------------------------------------------
// tbc_back: logarithm, beta equation and division pipeline
// Stalls as one piece when the final result register is not taken.
// ----------------------------------------------------------------------------
`default_nettype none
module tbc_back #(
  parameter int OUT_FRAC_BITS = tbc_pkg::DEF_OUT_FRAC_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire tbc_pkg::item_t                  in_item,
  output logic                                 in_ready,
  input  wire logic [tbc_pkg::BETA_W-1:0]      beta,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic signed [OUT_FRAC_BITS+9:0]      celsius_q8,
  output logic [tbc_pkg::STATUS_W-1:0]         status
);

  localparam int F     = OUT_FRAC_BITS;
  localparam int OUT_W = F + 10;
  localparam int QW    = tbc_pkg::KINT_W + F;
  localparam int TW    = QW + 2;
  localparam int LAT   = tbc_pkg::LOG2_LAT;
  localparam longint OFF_L  = (tbc_pkg::ZERO_C_X100 * (64'sd1 << F) + 50) / 100;
  localparam longint MAXC_L = (64'sd1 << (F + 8)) - 1;
  localparam logic signed [TW-1:0] OFF  = TW'(OFF_L);
  localparam logic signed [TW-1:0] MAXC = TW'(MAXC_L);

  logic en;
  logic out_valid;

  assign en       = !out_valid || pop;
  assign in_ready = en;
  assign empty    = !out_valid;

  // Logarithm lanes with a matching control line.
  logic [tbc_pkg::LOG_W-1:0] lg_num;
  logic [tbc_pkg::LOG_W-1:0] lg_den;
  logic [LAT-1:0]            lv;
  logic [1:0]                lcls [LAT];

  tbc_log2 u_log_num (.clk(clk), .en(en), .x(in_item.num), .result(lg_num));
  tbc_log2 u_log_den (.clk(clk), .en(en), .x(in_item.den), .result(lg_den));

  always_ff @(posedge clk) begin
    if (rst) begin
      lv <= '0;
    end else if (en) begin
      lv <= {lv[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lcls[0] <= in_item.cls;
      for (int i = 1; i < LAT; i++) begin
        lcls[i] <= lcls[i-1];
      end
    end
  end

  // Difference of logarithms, sign and magnitude.
  logic signed [tbc_pkg::LN_W-1:0] d;
  logic                            d_v;
  logic [1:0]                      d_cls;
  logic                            d_neg;
  logic [tbc_pkg::LOG_W-1:0]       d_mag;

  assign d = $signed({1'b0, lg_num}) - $signed({1'b0, lg_den});

  always_ff @(posedge clk) begin
    if (en) begin
      d_cls <= lcls[LAT-1];
      d_neg <= d[tbc_pkg::LN_W-1];
      d_mag <= d[tbc_pkg::LN_W-1] ? tbc_pkg::LOG_W'(-d) : tbc_pkg::LOG_W'(d);
    end
  end

  // Natural log by ln 2 scaling, rounded on the magnitude.
  logic [63:0]                     ln_prod;
  logic                            l_v;
  logic [1:0]                      l_cls;
  logic signed [tbc_pkg::LN_W-1:0] l_ln;
  logic [tbc_pkg::NUM_W-1:0]       l_n;
  logic [tbc_pkg::LOG_W-1:0]       ln_mag;

  assign ln_prod = 64'(d_mag) * 64'(tbc_pkg::LN2_Q32) + (64'd1 << 31);
  assign ln_mag  = ln_prod[32 +: tbc_pkg::LOG_W];

  always_ff @(posedge clk) begin
    if (en) begin
      l_cls <= d_cls;
      l_ln  <= d_neg ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
      l_n   <= {31'(tbc_pkg::T0_X100) * 31'(beta), 24'd0};
    end
  end

  // Scaled denominator of the beta equation.
  logic signed [tbc_pkg::DSUM_W-1:0] b_term;
  logic signed [tbc_pkg::DSUM_W-1:0] t_term;
  logic                              s_v;
  logic [1:0]                        s_cls;
  logic signed [tbc_pkg::DSUM_W-1:0] s_dsum;
  logic [tbc_pkg::NUM_W-1:0]         s_n;

  assign b_term = $signed({2'b00, 23'(beta) * 23'(tbc_pkg::BETA_SCALE), 24'd0});
  assign t_term = tbc_pkg::DSUM_W'($signed({1'b0, tbc_pkg::T0_X100}) * l_ln);

  always_ff @(posedge clk) begin
    if (en) begin
      s_cls  <= l_cls;
      s_dsum <= b_term + t_term;
      s_n    <= l_n;
    end
  end

  // Division set-up: nonpositive denominator or a quotient of 1024 and up.
  logic [tbc_pkg::DIV_W-1:0] dr  [QW+1];
  logic [QW-1:0]             dq  [QW+1];
  logic [tbc_pkg::DD_W-1:0]  ddv [QW+1];
  logic [1:0]                dcls [QW+1];
  logic [QW:0]               dv;
  logic                      ovf;
  logic                      nonpos;

  assign nonpos = s_dsum <= 0;
  assign ovf = tbc_pkg::DIV_W'(s_n)
               >= (tbc_pkg::DIV_W'(s_dsum[tbc_pkg::DD_W-1:0]) << tbc_pkg::KINT_W);

  always_ff @(posedge clk) begin
    if (en) begin
      dr[0]  <= tbc_pkg::DIV_W'(s_n);
      dq[0]  <= '0;
      ddv[0] <= s_dsum[tbc_pkg::DD_W-1:0];
      if (s_cls == tbc_pkg::CLS_OK && (nonpos || ovf)) begin
        dcls[0] <= tbc_pkg::CLS_MAX;
      end else begin
        dcls[0] <= s_cls;
      end
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [tbc_pkg::DIV_W-1:0] rs;
    logic [tbc_pkg::DIV_W-1:0] ds;
    logic                      qb;
    if (j < tbc_pkg::KINT_W) begin : g_int
      assign rs = dr[j];
      assign ds = tbc_pkg::DIV_W'(ddv[j]) << (tbc_pkg::KINT_W - 1 - j);
    end else begin : g_frac
      assign rs = dr[j] << 1;
      assign ds = tbc_pkg::DIV_W'(ddv[j]);
    end
    assign qb = rs >= ds;
    always_ff @(posedge clk) begin
      if (en) begin
        dr[j+1]   <= qb ? rs - ds : rs;
        dq[j+1]   <= {dq[j][QW-2:0], qb};
        ddv[j+1]  <= ddv[j];
        dcls[j+1] <= dcls[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (en) begin
      dv <= {dv[QW-1:0], s_v};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
      l_v <= 1'b0;
      s_v <= 1'b0;
    end else if (en) begin
      d_v <= lv[LAT-1];
      l_v <= d_v;
      s_v <= l_v;
    end
  end

  // Rounding, offset to Celsius and saturation.
  logic                     rnd;
  logic [QW:0]              qr;
  logic signed [TW-1:0]     tc;
  logic                     kcap;
  logic [OUT_W-1:0]         cel_next;
  logic [tbc_pkg::STATUS_W-1:0] st_next;

  assign rnd  = (dr[QW] << 1) >= tbc_pkg::DIV_W'(ddv[QW]);
  assign qr   = {1'b0, dq[QW]} + (QW+1)'(rnd);
  assign tc   = $signed({1'b0, qr}) - OFF;
  assign kcap = dq[QW][QW-1:F] > tbc_pkg::KELVIN_CAP;

  always_comb begin
    case (dcls[QW])
      tbc_pkg::CLS_RANGE: begin
        cel_next = '0;
        st_next  = tbc_pkg::ST_RANGE;
      end
      tbc_pkg::CLS_MAX: begin
        cel_next = OUT_W'(MAXC);
        st_next  = tbc_pkg::ST_SAT;
      end
      tbc_pkg::CLS_MIN: begin
        cel_next = OUT_W'(-OFF);
        st_next  = tbc_pkg::ST_SAT;
      end
      default: begin
        if (kcap || tc > MAXC) begin
          cel_next = OUT_W'(MAXC);
          st_next  = tbc_pkg::ST_SAT;
        end else begin
          cel_next = tc[OUT_W-1:0];
          st_next  = tbc_pkg::ST_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      celsius_q8 <= $signed(cel_next);
      status     <= st_next;
    end
  end

endmodule
`default_nettype wire
